FILE: rtl/core/chte_pkg.sv
// Shared types, constants and helper functions of the chained hash table engine.
`timescale 1ns / 1ps

package chte_pkg;

    localparam int MAX_BUCKETS_LOG2 = 10;
    localparam int POOL_NODES       = 1024;
    localparam int KEY_BYTES        = 8;

    localparam int MIN_BUCKETS_LOG2 = 1;
    localparam int MAX_BUCKETS      = 1 << MAX_BUCKETS_LOG2;
    localparam int KEY_W            = 8 * KEY_BYTES;
    localparam int LEN_W            = 4;
    localparam int LOG2_W           = 4;
    localparam int HASH_W           = 32;
    localparam int NODE_W           = $clog2(POOL_NODES);
    localparam int PTR_W            = NODE_W + 1;
    localparam int CNT_W            = $clog2(POOL_NODES + 1);
    localparam int BIDX_W           = MAX_BUCKETS_LOG2;
    localparam int BSIZE_W          = MAX_BUCKETS_LOG2 + 1;
    localparam int ROW_BITS         = 32;
    localparam int BIT_W            = $clog2(ROW_BITS);
    localparam int ROWS             = POOL_NODES / ROW_BITS;
    localparam int ROW_W            = $clog2(ROWS);
    localparam int CLR_LEN          = (MAX_BUCKETS > ROWS) ? MAX_BUCKETS : ROWS;
    localparam int CTR_W            = $clog2(CLR_LEN);
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 4;

    localparam logic [HASH_W-1:0] FNV_OFFSET = 32'h811c9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h01000193;
    localparam logic [PTR_W-1:0]  NIL        = PTR_W'(POOL_NODES);
    localparam logic [LOG2_W-1:0] RESET_LOG2 = 4'd4;

    typedef enum logic [1:0] {
        ACT_LOOKUP   = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_REMOVE_NR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_LOG2   = 2'd0,
        REG_AUTO_RESIZE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] key_len;
    } chte_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] handle;
        logic [CNT_W-1:0]  entry_count;
        logic [LOG2_W-1:0] buckets_log2;
    } chte_out_t;

    // Classified item passed from the hashing front to the table back end
    typedef struct packed {
        logic [1:0]        action;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [HASH_W-1:0] hash;
    } chte_job_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [HASH_W-1:0] hash;
    } node_data_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_HEAD, ST_HEADW, ST_CHK, ST_CMP, ST_UNLINK, ST_FREE,
        ST_SHRINK, ST_ALLOC, ST_ALLOCW, ST_GROW, ST_LINK, ST_LINKW,
        ST_RCLR, ST_RBKT, ST_RBKTW, ST_RNODE, ST_RNODEW, ST_RDST, ST_RDSTW, ST_DONE
    } back_state_t;

    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
        logic [LOG2_W-1:0] r;
        r = v;
        if (v < LOG2_W'(MIN_BUCKETS_LOG2)) r = LOG2_W'(MIN_BUCKETS_LOG2);
        if (v > LOG2_W'(MAX_BUCKETS_LOG2)) r = LOG2_W'(MAX_BUCKETS_LOG2);
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : v;
    endfunction

    function automatic logic [KEY_W-1:0] used_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (LEN_W'(i) < len) m[8*i +: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [BSIZE_W-1:0] bucket_size(input logic [LOG2_W-1:0] l2);
        return BSIZE_W'(1) << l2;
    endfunction

    function automatic logic [BIDX_W-1:0] bucket_mask(input logic [LOG2_W-1:0] l2);
        logic [BSIZE_W-1:0] s;
        s = (BSIZE_W'(1) << l2) - BSIZE_W'(1);
        return s[BIDX_W-1:0];
    endfunction

    // Position of the lowest clear bit (all-ones input gives zero)
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [ROW_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] lowest_zero_row(input logic [ROWS-1:0] v);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!v[i]) r = ROW_W'(i);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/chte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/chte_front.sv
// Front end: accepts items, clamps and masks the key, hashes it one byte per cycle.
`timescale 1ns / 1ps

module chte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  chte_pkg::chte_in_t  in_data,
    output logic                job_valid,
    input  logic                job_ready,
    output chte_pkg::chte_job_t job
);
    import chte_pkg::*;

    logic                busy_reg, busy_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    chte_job_t           job_reg, job_next;
    logic [HASH_W-1:0]   mixed;
    logic [LEN_W-1:0]    len_c;
    logic                hashing;

    assign in_ready  = !busy_reg;
    assign hashing   = busy_reg && (cnt_reg < job_reg.key_len);
    assign job_valid = busy_reg && !hashing;
    assign len_c     = clamp_len(in_data.key_len);
    assign mixed     = hash_reg ^ {24'b0, job_reg.key[8*cnt_reg[2:0] +: 8]};

    always_comb
    begin
        job              = job_reg;
        job.hash         = hash_reg;
        busy_next        = busy_reg;
        cnt_next         = cnt_reg;
        hash_next        = hash_reg;
        job_next         = job_reg;
        // FNV-1a step: one byte per cycle
        if (hashing)
        begin
            hash_next = mixed * FNV_PRIME;
            cnt_next  = cnt_reg + LEN_W'(1);
        end
        if (job_valid && job_ready)
        begin
            busy_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            busy_next        = 1'b1;
            cnt_next         = '0;
            hash_next        = FNV_OFFSET;
            job_next.action  = in_data.action;
            job_next.key_len = len_c;
            job_next.key     = in_data.key & used_mask(len_c);
            job_next.hash    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        hash_reg <= hash_next;
        job_reg  <= job_next;
    end

endmodule

FILE: rtl/core/chte_queue.sv
// Two-entry item queue between the hashing front and the table back end.
`timescale 1ns / 1ps

module chte_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  chte_pkg::chte_job_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output chte_pkg::chte_job_t pop_data
);
    import chte_pkg::*;

    chte_job_t  slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        fill_next = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/chte_back.sv
// Back end: table sequencer over bucket, node and allocation memories, with result register.
`timescale 1ns / 1ps

module chte_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  chte_pkg::chte_job_t                job,
    output logic                               out_valid,
    input  logic                               out_ready,
    output chte_pkg::chte_out_t                out_data,
    input  logic                               cfg_valid,
    input  logic [chte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chte_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import chte_pkg::*;

    back_state_t        state_reg, state_next;
    logic               act_reg, act_next;
    logic [LOG2_W-1:0]  log2_reg, log2_next;
    logic [LOG2_W-1:0]  new_log2_reg, new_log2_next;
    logic [LOG2_W-1:0]  init_reg, init_next;
    logic               auto_reg, auto_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ROWS-1:0]    full_reg, full_next;
    chte_job_t          job_reg, job_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [PTR_W-1:0]   prev_reg, prev_next;
    logic [PTR_W-1:0]   nxt_reg, nxt_next;
    logic [NODE_W-1:0]  n_reg, n_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BIDX_W-1:0]  ridx_reg, ridx_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic               ret_ins_reg, ret_ins_next;
    logic [1:0]         stat_reg, stat_next;
    logic               ov_reg, ov_next;
    chte_out_t          res_reg, res_next;

    // Memory ports
    logic               bk_we0, bk_we1;
    logic [BIDX_W-1:0]  bk_waddr, bk_raddr;
    logic [PTR_W-1:0]   bk_wdata, bk_rd0, bk_rd1, bk_rd_act, bk_rd_dst;
    logic               nx_we;
    logic [NODE_W-1:0]  nx_waddr, nd_raddr;
    logic [PTR_W-1:0]   nx_wdata, nx_rdata;
    logic               nd_we;
    node_data_t         nd_wdata, nd_rdata;
    logic               iu_we;
    logic [ROW_W-1:0]   iu_waddr, iu_raddr;
    logic [ROW_BITS-1:0] iu_wdata, iu_rdata;

    logic [BIDX_W-1:0]  bidx;
    logic [BIT_W-1:0]   fbit;
    logic [ROW_BITS-1:0] bit_onehot, p_onehot;
    logic [BSIZE_W-1:0] size_cur, size_new;
    logic               key_match;

    assign bk_rd_act = act_reg ? bk_rd1 : bk_rd0;
    assign bk_rd_dst = act_reg ? bk_rd0 : bk_rd1;
    assign bidx      = job_reg.hash[BIDX_W-1:0] & bucket_mask(log2_reg);
    assign size_cur  = bucket_size(log2_reg);
    assign size_new  = bucket_size(new_log2_reg);
    assign fbit      = lowest_zero(iu_rdata);
    assign bit_onehot = ROW_BITS'(1) << fbit;
    assign p_onehot  = ROW_BITS'(1) << p_reg[BIT_W-1:0];
    assign key_match = (nd_rdata.key_len == job_reg.key_len) && (nd_rdata.key == job_reg.key);

    assign job_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    chte_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_bucket0 (
        .clk(clk), .we(bk_we0), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rd0)
    );

    chte_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_bucket1 (
        .clk(clk), .we(bk_we1), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rd1)
    );

    chte_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_node_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nd_raddr), .rdata(nx_rdata)
    );

    chte_ram #(.WIDTH($bits(node_data_t)), .DEPTH(POOL_NODES)) u_node_data (
        .clk(clk), .we(nd_we), .waddr(n_reg), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );

    chte_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_in_use (
        .clk(clk), .we(iu_we), .waddr(iu_waddr), .wdata(iu_wdata),
        .raddr(iu_raddr), .rdata(iu_rdata)
    );

    // Sequencer: next state, memory controls and result
    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        log2_next    = log2_reg;
        new_log2_next = new_log2_reg;
        init_next    = init_reg;
        auto_next    = auto_reg;
        count_next   = count_reg;
        full_next    = full_reg;
        job_next     = job_reg;
        p_next       = p_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        n_next       = n_reg;
        row_next     = row_reg;
        ridx_next    = ridx_reg;
        ctr_next     = ctr_reg;
        ret_ins_next = ret_ins_reg;
        stat_next    = stat_reg;
        ov_next      = ov_reg;
        res_next     = res_reg;

        bk_we0   = 1'b0;
        bk_we1   = 1'b0;
        bk_waddr = bidx;
        bk_wdata = NIL;
        bk_raddr = bidx;
        nx_we    = 1'b0;
        nx_waddr = n_reg;
        nx_wdata = NIL;
        nd_we    = 1'b0;
        nd_wdata = '{key: job_reg.key, key_len: job_reg.key_len, hash: job_reg.hash};
        nd_raddr = p_reg[NODE_W-1:0];
        iu_we    = 1'b0;
        iu_waddr = row_reg;
        iu_wdata = '0;
        iu_raddr = row_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            // Empty the active bucket bank and the allocation rows
            ST_CLEAR:
            begin
                bk_waddr = ctr_reg[BIDX_W-1:0];
                bk_we0   = !act_reg && (32'(ctr_reg) < MAX_BUCKETS);
                bk_we1   = act_reg && (32'(ctr_reg) < MAX_BUCKETS);
                iu_waddr = ctr_reg[ROW_W-1:0];
                iu_we    = (32'(ctr_reg) < ROWS);
                ctr_next = ctr_reg + CTR_W'(1);
                if (ctr_reg == CTR_W'(CLR_LEN - 1))
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_valid && !ov_reg)
                begin
                    job_next = job;
                    if (job.action == ACT_INSERT)
                    begin
                        if (&full_reg)
                        begin
                            stat_next  = STAT_FULL;
                            n_next     = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ALLOC;
                        end
                    end
                    else
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            // Chain walk for lookup and remove
            ST_HEAD:
            begin
                state_next = ST_HEADW;
            end
            ST_HEADW:
            begin
                p_next     = bk_rd_act;
                prev_next  = NIL;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (p_reg[NODE_W])
                begin
                    stat_next  = STAT_MISS;
                    n_next     = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (key_match)
                begin
                    n_next   = p_reg[NODE_W-1:0];
                    nxt_next = nx_rdata;
                    if (job_reg.action == ACT_LOOKUP)
                    begin
                        stat_next  = STAT_OK;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_UNLINK;
                    end
                end
                else
                begin
                    prev_next  = p_reg;
                    p_next     = nx_rdata;
                    state_next = ST_CHK;
                end
            end
            ST_UNLINK:
            begin
                if (prev_reg[NODE_W])
                begin
                    bk_wdata = nxt_reg;
                    bk_we0   = !act_reg;
                    bk_we1   = act_reg;
                end
                else
                begin
                    nx_waddr = prev_reg[NODE_W-1:0];
                    nx_wdata = nxt_reg;
                    nx_we    = 1'b1;
                end
                iu_raddr   = p_reg[NODE_W-1:BIT_W];
                state_next = ST_FREE;
            end
            ST_FREE:
            begin
                iu_waddr = p_reg[NODE_W-1:BIT_W];
                iu_wdata = iu_rdata & ~p_onehot;
                iu_we    = 1'b1;
                full_next[p_reg[NODE_W-1:BIT_W]] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_SHRINK;
            end
            ST_SHRINK:
            begin
                stat_next = STAT_OK;
                if (auto_reg && (job_reg.action == ACT_REMOVE)
                    && (count_reg <= CNT_W'(size_cur >> 1))
                    && (log2_reg > LOG2_W'(MIN_BUCKETS_LOG2)))
                begin
                    new_log2_next = log2_reg - LOG2_W'(1);
                    ret_ins_next  = 1'b0;
                    ctr_next      = '0;
                    state_next    = ST_RCLR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            // Insert: lowest free node, optional growth, push on chain head
            ST_ALLOC:
            begin
                row_next   = lowest_zero_row(full_reg);
                iu_raddr   = lowest_zero_row(full_reg);
                state_next = ST_ALLOCW;
            end
            ST_ALLOCW:
            begin
                n_next   = {row_reg, fbit};
                iu_wdata = iu_rdata | bit_onehot;
                iu_we    = 1'b1;
                full_next[row_reg] = &(iu_rdata | bit_onehot);
                state_next = ST_GROW;
            end
            ST_GROW:
            begin
                if (auto_reg && (CNT_W'(size_cur) <= count_reg)
                    && (log2_reg < LOG2_W'(MAX_BUCKETS_LOG2)))
                begin
                    new_log2_next = log2_reg + LOG2_W'(1);
                    ret_ins_next  = 1'b1;
                    ctr_next      = '0;
                    state_next    = ST_RCLR;
                end
                else
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_LINKW;
            end
            ST_LINKW:
            begin
                nd_we      = 1'b1;
                nx_wdata   = bk_rd_act;
                nx_we      = 1'b1;
                bk_wdata   = {1'b0, n_reg};
                bk_we0     = !act_reg;
                bk_we1     = act_reg;
                count_next = count_reg + CNT_W'(1);
                stat_next  = STAT_OK;
                state_next = ST_DONE;
            end
            // Rehash: clear the other bank, then move nodes bucket by bucket
            ST_RCLR:
            begin
                bk_waddr = ctr_reg[BIDX_W-1:0];
                bk_we0   = act_reg;
                bk_we1   = !act_reg;
                ctr_next = ctr_reg + CTR_W'(1);
                if (ctr_reg == CTR_W'(size_new - BSIZE_W'(1)))
                begin
                    ctr_next   = '0;
                    state_next = ST_RBKT;
                end
            end
            ST_RBKT:
            begin
                bk_raddr   = ctr_reg[BIDX_W-1:0];
                state_next = ST_RBKTW;
            end
            ST_RBKTW:
            begin
                p_next     = bk_rd_act;
                state_next = ST_RNODE;
            end
            ST_RNODE:
            begin
                if (p_reg[NODE_W])
                begin
                    if (ctr_reg == CTR_W'(size_cur - BSIZE_W'(1)))
                    begin
                        ctr_next   = '0;
                        act_next   = !act_reg;
                        log2_next  = new_log2_reg;
                        state_next = ret_ins_reg ? ST_LINK : ST_DONE;
                    end
                    else
                    begin
                        ctr_next   = ctr_reg + CTR_W'(1);
                        state_next = ST_RBKT;
                    end
                end
                else
                begin
                    state_next = ST_RNODEW;
                end
            end
            ST_RNODEW:
            begin
                nxt_next   = nx_rdata;
                ridx_next  = nd_rdata.hash[BIDX_W-1:0] & bucket_mask(new_log2_reg);
                state_next = ST_RDST;
            end
            ST_RDST:
            begin
                bk_raddr   = ridx_reg;
                state_next = ST_RDSTW;
            end
            ST_RDSTW:
            begin
                nx_waddr   = p_reg[NODE_W-1:0];
                nx_wdata   = bk_rd_dst;
                nx_we      = 1'b1;
                bk_waddr   = ridx_reg;
                bk_wdata   = p_reg;
                bk_we0     = act_reg;
                bk_we1     = !act_reg;
                p_next     = nxt_reg;
                state_next = ST_RNODE;
            end
            // Load the result register
            ST_DONE:
            begin
                ov_next  = 1'b1;
                res_next = '{status: stat_reg, handle: n_reg,
                             entry_count: count_reg, buckets_log2: log2_reg};
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; the initial size write empties the table
        if (cfg_valid)
        begin
            if (cfg_index == REG_INIT_LOG2)
            begin
                init_next  = cfg_data;
                log2_next  = clamp_log2(cfg_data);
                count_next = '0;
                full_next  = '0;
                ctr_next   = '0;
                state_next = ST_CLEAR;
            end
            else if (cfg_index == REG_AUTO_RESIZE)
            begin
                auto_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            act_reg   <= 1'b0;
            log2_reg  <= RESET_LOG2;
            init_reg  <= RESET_LOG2;
            auto_reg  <= 1'b0;
            count_reg <= '0;
            full_reg  <= '0;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            log2_reg  <= log2_next;
            init_reg  <= init_next;
            auto_reg  <= auto_next;
            count_reg <= count_next;
            full_reg  <= full_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_log2_reg <= new_log2_next;
        job_reg      <= job_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        n_reg        <= n_next;
        row_reg      <= row_next;
        ridx_reg     <= ridx_next;
        ret_ins_reg  <= ret_ins_next;
        stat_reg     <= stat_next;
        res_reg      <= res_next;
    end

endmodule

FILE: rtl/core/chained_hash_table_engine.sv
// The front hashes the key bytes; the back end then walks the bucket chain (lookup;
// remove also unlinks and frees the node) or links a new node (insert), then loads
// the result register. A resize clears the other bank and moves every node into it.
// One item is processed by the back end at a time; the front hashes the next meanwhile.
// After reset, and after a write of the initial size register, a clearing pass runs
// over the bucket and allocation memories before items are taken.
`timescale 1ns / 1ps

module chained_hash_table_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  chte_pkg::chte_in_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output chte_pkg::chte_out_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [chte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chte_pkg::CFG_DATA_W-1:0] cfg_data
);
    import chte_pkg::*;

    logic      fq_valid, fq_ready, qb_valid, qb_ready;
    chte_job_t fq_job, qb_job;

    assign cfg_ready = 1'b1;

    chte_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    chte_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(fq_valid), .push_ready(fq_ready), .push_data(fq_job),
        .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(qb_job)
    );

    chte_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

endmodule

FILE: rtl/core/chte_checker.sv
// Port-level assertions for the chained hash table engine, bound to the top level.
`timescale 1ns / 1ps

module chte_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  chte_pkg::chte_out_t out_data
);
    import chte_pkg::*;

    // A result held back stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Miss and full results carry no node handle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STAT_MISS || out_data.status == STAT_FULL)
        |-> out_data.handle == '0)
        else $error("handle set on failed request");

    // Entry count stays within the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= CNT_W'(POOL_NODES))
        else $error("entry count beyond pool");

    // Bucket count stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.buckets_log2 >= LOG2_W'(MIN_BUCKETS_LOG2))
                      && (out_data.buckets_log2 <= LOG2_W'(MAX_BUCKETS_LOG2)))
        else $error("bucket count out of range");

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
);
